### rtl/buddy_block_allocator_unit_defines.svh
// assertion macros used by the port checker file
`ifndef BUDDY_BLOCK_ALLOCATOR_UNIT_DEFINES_SVH
`define BUDDY_BLOCK_ALLOCATOR_UNIT_DEFINES_SVH

// same-cycle implication, sampled on clk, off while rst is high
`define BBA_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, sampled on clk, off while rst is high
`define BBA_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### rtl/bba_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bba_pkg
// types, constants and helpers of the buddy block allocator
// ----------------------------------------------------------------------------
package bba_pkg;

  localparam int REGION_EXP    = 20;
  localparam int MIN_BLOCK_EXP = 12;
  localparam int LEVELS        = (REGION_EXP >= MIN_BLOCK_EXP) ?
                                 (REGION_EXP - MIN_BLOCK_EXP + 1) : 1;
  localparam int NODE_COUNT    = (1 << LEVELS) - 1;
  localparam int NODE_W        = $clog2(NODE_COUNT);
  localparam int LVL_W         = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int J_W           = (LEVELS > 1) ? (LEVELS - 1) : 1;
  localparam int CNT_W         = LEVELS;
  localparam int ADDR_W        = 32;
  localparam int STATUS_W      = 2;
  localparam int IN_W          = 72;
  localparam int OUT_W         = 40;
  localparam logic [ADDR_W-1:0] BASE_RESET = 32'h0060_0000;
  localparam logic [LVL_W-1:0]  LAST_LVL   = LVL_W'(LEVELS - 1);

  typedef enum logic [1:0] {
    NODE_UNUSED = 2'd0,
    NODE_FREE   = 2'd1,
    NODE_TAKEN  = 2'd2,
    NODE_SPLIT  = 2'd3
  } node_st_t;

  typedef enum logic [STATUS_W-1:0] {
    STS_OK        = 2'd0,
    STS_TOO_LARGE = 2'd1,
    STS_NO_FREE   = 2'd2,
    STS_NOT_ALLOC = 2'd3
  } status_t;

  typedef enum logic {
    CMD_ALLOC = 1'b0,
    CMD_FREE  = 1'b1
  } cmd_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DECODE,
    ST_A_SCAN,
    ST_A_SPLIT,
    ST_A_SIB,
    ST_A_TAKE,
    ST_F_RD,
    ST_F_CHK,
    ST_F_BUD_RD,
    ST_F_BUD_CHK,
    ST_F_M1,
    ST_F_M2,
    ST_F_FINAL,
    ST_DONE
  } state_t;

  // level-order index of node j at level lvl
  function automatic logic [NODE_W-1:0] tree_addr(input logic [LVL_W-1:0] lvl,
                                                  input logic [J_W-1:0] j);
    logic [NODE_W-1:0] first;
    first = (NODE_W'(1) << lvl) - NODE_W'(1);
    return first + NODE_W'(j);
  endfunction

  // byte offset of node j at level lvl inside the region
  function automatic logic [ADDR_W-1:0] node_off(input logic [LVL_W-1:0] lvl,
                                                 input logic [J_W-1:0] j);
    logic [LVL_W:0] sh;
    sh = (LVL_W+1)'(REGION_EXP) - {1'b0, lvl};
    return ADDR_W'(j) << sh;
  endfunction

  // highest node index within a level
  function automatic logic [J_W-1:0] last_j(input logic [LVL_W-1:0] lvl);
    return (J_W'(1) << lvl) - J_W'(1);
  endfunction

endpackage

### rtl/bba_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bba_ram
// generic simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module bba_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 511
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/buddy_block_allocator_unit.sv
`timescale 1ns / 1ps
// allocate: decode, scan the nearest level with a free node (up to 256 nodes),
//   then split down to the target level and take; free: probe from the root,
//   merge with free buddies and write back; a rejected allocate skips the scan
// one command in flight; the next word is taken once the result is registered
// reset: synchronous; a clear pass then writes all 511 tree nodes (root free)
//   while s_tready stays low, configuration writes are taken throughout
// ----------------------------------------------------------------------------
// buddy_block_allocator_unit
// binary buddy allocator over a 1 MiB region with 4 KiB minimum blocks
// ----------------------------------------------------------------------------
module buddy_block_allocator_unit (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_wen,
  input  logic [31:0]                cfg_wdata,
  input  logic                       s_tvalid,
  output logic                       s_tready,
  input  logic [bba_pkg::IN_W-1:0]   s_tdata,   // cmd, request_size, free_address, zero pad
  output logic                       m_tvalid,
  input  logic                       m_tready,
  output logic [bba_pkg::OUT_W-1:0]  m_tdata    // block_address, status, zero pad
);

  bba_pkg::state_t state, state_next;

  logic [bba_pkg::NODE_W-1:0]   clr_addr;
  logic [bba_pkg::ADDR_W-1:0]   base;
  logic                         cmd_r;
  logic [bba_pkg::ADDR_W-1:0]   req_r;
  logic [bba_pkg::ADDR_W-1:0]   faddr_r;
  logic [bba_pkg::LVL_W-1:0]    lvl;
  logic [bba_pkg::LVL_W-1:0]    tgt;
  logic [bba_pkg::J_W-1:0]      jr;
  logic [bba_pkg::J_W-1:0]      sj;
  logic [bba_pkg::J_W-1:0]      pj;
  logic                         pv;
  logic [bba_pkg::CNT_W-1:0]    cnt [bba_pkg::LEVELS];
  logic [bba_pkg::ADDR_W-1:0]   res_addr;
  logic [bba_pkg::STATUS_W-1:0] res_status;

  // ram ports
  logic                       ram_we;
  logic [bba_pkg::NODE_W-1:0] ram_waddr;
  logic [1:0]                 ram_wdata;
  logic                       ram_re;
  logic [bba_pkg::NODE_W-1:0] ram_raddr;
  logic [1:0]                 ram_rdata;

  bba_ram #(
    .WIDTH(2),
    .DEPTH(bba_pkg::NODE_COUNT)
  ) u_tree (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // allocate decode: target level and nearest level with a free node
  logic [bba_pkg::LVL_W-1:0] tgt_c;
  logic [bba_pkg::LVL_W-1:0] srch_c;
  logic                      too_large;
  logic                      found_c;

  always_comb begin
    tgt_c = '0;
    for (int l = 1; l < bba_pkg::LEVELS; l++) begin
      if ({1'b0, req_r} <= (33'(1) << (bba_pkg::REGION_EXP - l))) begin
        tgt_c = bba_pkg::LVL_W'(l);
      end
    end
    too_large = {1'b0, req_r} > (33'(1) << bba_pkg::REGION_EXP);
    srch_c  = '0;
    found_c = 1'b0;
    for (int l = 0; l < bba_pkg::LEVELS; l++) begin
      if (bba_pkg::LVL_W'(l) <= tgt_c && cnt[l] != '0) begin
        srch_c  = bba_pkg::LVL_W'(l);
        found_c = 1'b1;
      end
    end
  end

  // free decode: candidate node at the current probe level
  logic [bba_pkg::ADDR_W-1:0] foff;
  logic                       in_region;
  logic                       aligned;
  logic [bba_pkg::J_W-1:0]    fj;
  logic [bba_pkg::LVL_W:0]    fsh;

  always_comb begin
    foff      = faddr_r - base;
    in_region = (foff >> bba_pkg::REGION_EXP) == '0;
    fsh       = (bba_pkg::LVL_W+1)'(bba_pkg::REGION_EXP) - {1'b0, lvl};
    aligned   = (foff & ((bba_pkg::ADDR_W'(1) << fsh) - bba_pkg::ADDR_W'(1))) == '0;
    fj        = bba_pkg::J_W'(foff >> fsh);
  end

  logic scan_hit;
  logic scan_end;
  logic out_free;

  assign scan_hit = pv && (ram_rdata == bba_pkg::NODE_FREE);
  assign scan_end = pv && (pj == bba_pkg::last_j(lvl));
  assign out_free = !m_tvalid || m_tready;
  assign s_tready = (state == bba_pkg::ST_IDLE);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      bba_pkg::ST_CLEAR: begin
        if (clr_addr == bba_pkg::NODE_W'(bba_pkg::NODE_COUNT - 1)) begin
          state_next = bba_pkg::ST_IDLE;
        end
      end
      bba_pkg::ST_IDLE: begin
        if (s_tvalid) begin
          state_next = bba_pkg::ST_DECODE;
        end
      end
      bba_pkg::ST_DECODE: begin
        if (cmd_r == bba_pkg::CMD_FREE) begin
          state_next = bba_pkg::ST_F_RD;
        end else if (too_large || !found_c) begin
          state_next = bba_pkg::ST_DONE;
        end else begin
          state_next = bba_pkg::ST_A_SCAN;
        end
      end
      bba_pkg::ST_A_SCAN: begin
        if (scan_hit) begin
          state_next = (lvl < tgt) ? bba_pkg::ST_A_SPLIT : bba_pkg::ST_A_TAKE;
        end else if (scan_end) begin
          state_next = bba_pkg::ST_DONE;
        end
      end
      bba_pkg::ST_A_SPLIT: state_next = bba_pkg::ST_A_SIB;
      bba_pkg::ST_A_SIB: begin
        state_next = (lvl < tgt) ? bba_pkg::ST_A_SPLIT : bba_pkg::ST_A_TAKE;
      end
      bba_pkg::ST_A_TAKE: state_next = bba_pkg::ST_DONE;
      bba_pkg::ST_F_RD: begin
        if (!in_region) begin
          state_next = bba_pkg::ST_DONE;
        end else if (aligned) begin
          state_next = bba_pkg::ST_F_CHK;
        end else if (lvl == bba_pkg::LAST_LVL) begin
          state_next = bba_pkg::ST_DONE;
        end
      end
      bba_pkg::ST_F_CHK: begin
        if (ram_rdata == bba_pkg::NODE_TAKEN) begin
          state_next = bba_pkg::ST_F_BUD_RD;
        end else if (lvl == bba_pkg::LAST_LVL) begin
          state_next = bba_pkg::ST_DONE;
        end else begin
          state_next = bba_pkg::ST_F_RD;
        end
      end
      bba_pkg::ST_F_BUD_RD: begin
        state_next = (lvl == '0) ? bba_pkg::ST_F_FINAL : bba_pkg::ST_F_BUD_CHK;
      end
      bba_pkg::ST_F_BUD_CHK: begin
        state_next = (ram_rdata == bba_pkg::NODE_FREE) ? bba_pkg::ST_F_M1
                                                       : bba_pkg::ST_F_FINAL;
      end
      bba_pkg::ST_F_M1:    state_next = bba_pkg::ST_F_M2;
      bba_pkg::ST_F_M2:    state_next = bba_pkg::ST_F_BUD_RD;
      bba_pkg::ST_F_FINAL: state_next = bba_pkg::ST_DONE;
      bba_pkg::ST_DONE: begin
        if (out_free) begin
          state_next = bba_pkg::ST_IDLE;
        end
      end
      default: state_next = bba_pkg::ST_IDLE;
    endcase
  end

  // tree ram control
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = bba_pkg::tree_addr(lvl, jr);
    ram_wdata = bba_pkg::NODE_UNUSED;
    ram_re    = 1'b0;
    ram_raddr = bba_pkg::tree_addr(lvl, jr);
    unique case (state)
      bba_pkg::ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_addr;
        ram_wdata = (clr_addr == '0) ? bba_pkg::NODE_FREE : bba_pkg::NODE_UNUSED;
      end
      bba_pkg::ST_A_SCAN: begin
        ram_re    = 1'b1;
        ram_raddr = bba_pkg::tree_addr(lvl, sj);
      end
      bba_pkg::ST_A_SPLIT: begin
        ram_we    = 1'b1;
        ram_wdata = bba_pkg::NODE_SPLIT;
      end
      bba_pkg::ST_A_SIB: begin
        ram_we    = 1'b1;
        ram_waddr = bba_pkg::tree_addr(lvl, jr | bba_pkg::J_W'(1));
        ram_wdata = bba_pkg::NODE_FREE;
      end
      bba_pkg::ST_A_TAKE: begin
        ram_we    = 1'b1;
        ram_wdata = bba_pkg::NODE_TAKEN;
      end
      bba_pkg::ST_F_RD: begin
        ram_re    = in_region && aligned;
        ram_raddr = bba_pkg::tree_addr(lvl, fj);
      end
      bba_pkg::ST_F_BUD_RD: begin
        ram_re    = (lvl != '0);
        ram_raddr = bba_pkg::tree_addr(lvl, jr ^ bba_pkg::J_W'(1));
      end
      bba_pkg::ST_F_M1: begin
        ram_we = 1'b1;
      end
      bba_pkg::ST_F_M2: begin
        ram_we    = 1'b1;
        ram_waddr = bba_pkg::tree_addr(lvl, jr ^ bba_pkg::J_W'(1));
      end
      bba_pkg::ST_F_FINAL: begin
        ram_we    = 1'b1;
        ram_wdata = bba_pkg::NODE_FREE;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= bba_pkg::ST_CLEAR;
      clr_addr <= '0;
      base     <= bba_pkg::BASE_RESET;
      m_tvalid <= 1'b0;
      pv       <= 1'b0;
      for (int l = 0; l < bba_pkg::LEVELS; l++) begin
        cnt[l] <= (l == 0) ? bba_pkg::CNT_W'(1) : '0;
      end
    end else begin
      state <= state_next;
      if (cfg_wen) begin
        base <= cfg_wdata;
      end
      if (state == bba_pkg::ST_DONE && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        bba_pkg::ST_CLEAR: begin
          clr_addr <= clr_addr + bba_pkg::NODE_W'(1);
        end
        bba_pkg::ST_IDLE: begin
          cmd_r   <= s_tdata[0];
          req_r   <= s_tdata[32:1];
          faddr_r <= s_tdata[64:33];
        end
        bba_pkg::ST_DECODE: begin
          res_addr <= '0;
          pv       <= 1'b0;
          sj       <= '0;
          tgt      <= tgt_c;
          if (cmd_r == bba_pkg::CMD_FREE) begin
            lvl        <= '0;
            res_status <= bba_pkg::STS_NOT_ALLOC;
          end else begin
            lvl <= srch_c;
            if (too_large) begin
              res_status <= bba_pkg::STS_TOO_LARGE;
            end else begin
              res_status <= bba_pkg::STS_NO_FREE;
            end
          end
        end
        bba_pkg::ST_A_SCAN: begin
          pv <= 1'b1;
          pj <= sj;
          sj <= sj + bba_pkg::J_W'(1);
          if (scan_hit) begin
            jr <= pj;
          end
        end
        bba_pkg::ST_A_SPLIT: begin
          cnt[lvl] <= cnt[lvl] - bba_pkg::CNT_W'(1);
          lvl      <= lvl + bba_pkg::LVL_W'(1);
          jr       <= jr << 1;
        end
        bba_pkg::ST_A_SIB: begin
          cnt[lvl] <= cnt[lvl] + bba_pkg::CNT_W'(2);
        end
        bba_pkg::ST_A_TAKE: begin
          cnt[lvl]   <= cnt[lvl] - bba_pkg::CNT_W'(1);
          res_addr   <= base + bba_pkg::node_off(lvl, jr);
          res_status <= bba_pkg::STS_OK;
        end
        bba_pkg::ST_F_RD: begin
          jr <= fj;
          if (in_region && !aligned && lvl != bba_pkg::LAST_LVL) begin
            lvl <= lvl + bba_pkg::LVL_W'(1);
          end
        end
        bba_pkg::ST_F_CHK: begin
          if (ram_rdata != bba_pkg::NODE_TAKEN && lvl != bba_pkg::LAST_LVL) begin
            lvl <= lvl + bba_pkg::LVL_W'(1);
          end
        end
        bba_pkg::ST_F_M2: begin
          // buddy leaves this level, the pair moves up as one node
          cnt[lvl] <= cnt[lvl] - bba_pkg::CNT_W'(1);
          lvl      <= lvl - bba_pkg::LVL_W'(1);
          jr       <= jr >> 1;
        end
        bba_pkg::ST_F_FINAL: begin
          cnt[lvl]   <= cnt[lvl] + bba_pkg::CNT_W'(1);
          res_status <= bba_pkg::STS_OK;
        end
        bba_pkg::ST_DONE: begin
          if (out_free) begin
            m_tdata <= {6'd0, res_status, res_addr};
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

### rtl/bba_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bba_checker
// port-level checks on the buddy block allocator, bound to the top level
// ----------------------------------------------------------------------------
`include "buddy_block_allocator_unit_defines.svh"

module bba_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [39:0] m_tdata
);

  // stalled result word holds
  `BBA_ASSERT_NXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

  // one command at a time
  `BBA_ASSERT_NXT(a_one_busy, s_tvalid && s_tready, !s_tready)

  // failed results (nonzero status) carry a zero address
  `BBA_ASSERT_IMP(a_fail_zero, m_tvalid && m_tdata[33:32] != 2'd0, m_tdata[31:0] == 32'd0)

  // pad bits stay zero
  `BBA_ASSERT_IMP(a_pad_zero, m_tvalid, m_tdata[39:34] == 6'd0)

endmodule

bind buddy_block_allocator_unit bba_checker u_bba_checker (.*);

### sim/bba_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bba_scoreboard
// watches the command and result streams, tracks the buddy tree on its own and
// compares every result word with the predicted address and status
// ----------------------------------------------------------------------------
module bba_scoreboard
  import bba_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wen,
  input  logic [31:0] cfg_wdata,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [71:0] s_tdata,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [39:0] m_tdata,
  output int          errors,
  output int          pending
);

  typedef struct packed {
    logic [31:0] addr;
    status_t     sts;
  } alloc_result_t;

  node_st_t      tree [NODE_COUNT];
  int unsigned   free_cnt [LEVELS];
  logic [31:0]   base;
  alloc_result_t result_q [$];

  assign pending = result_q.size();

  function automatic int tree_pos(int lvl, int j);
    return (1 << lvl) - 1 + j;
  endfunction

  function automatic logic [31:0] blk_addr(int lvl, int j);
    return base + (32'(j) << (REGION_EXP - lvl));
  endfunction

  function automatic alloc_result_t alloc_block(logic [31:0] req);
    alloc_result_t r;
    int e, target, lvl, j;
    r.addr = '0;
    r.sts  = STS_OK;
    e = MIN_BLOCK_EXP;
    while (e <= REGION_EXP && (64'd1 << e) < {32'd0, req}) e++;
    if (e > REGION_EXP) begin
      r.sts = STS_TOO_LARGE;
      return r;
    end
    target = REGION_EXP - e;
    if (target >= LEVELS) target = LEVELS - 1;
    lvl = target;
    while (lvl >= 0 && free_cnt[lvl] == 0) lvl--;
    j = -1;
    if (lvl >= 0)
      for (int k = 0; k < (1 << lvl); k++)
        if (j < 0 && tree[tree_pos(lvl, k)] == NODE_FREE) j = k;
    if (j < 0) begin
      r.sts = STS_NO_FREE;
      return r;
    end
    // split down the left side to the target size
    while (lvl < target) begin
      tree[tree_pos(lvl, j)] = NODE_SPLIT;
      free_cnt[lvl]--;
      lvl++;
      j = j * 2;
      tree[tree_pos(lvl, j)]     = NODE_FREE;
      tree[tree_pos(lvl, j + 1)] = NODE_FREE;
      free_cnt[lvl] += 2;
    end
    tree[tree_pos(lvl, j)] = NODE_TAKEN;
    free_cnt[lvl]--;
    r.addr = blk_addr(lvl, j);
    return r;
  endfunction

  function automatic alloc_result_t release_block(logic [31:0] addr);
    alloc_result_t r;
    int lvl, j, bud;
    r.addr = '0;
    r.sts  = STS_NOT_ALLOC;
    lvl = -1;
    j = 0;
    for (int l = 0; l < LEVELS; l++)
      for (int k = 0; k < (1 << l); k++)
        if (lvl < 0 && tree[tree_pos(l, k)] == NODE_TAKEN && blk_addr(l, k) == addr) begin
          lvl = l;
          j = k;
        end
    if (lvl < 0) return r;
    tree[tree_pos(lvl, j)] = NODE_FREE;
    free_cnt[lvl]++;
    while (lvl > 0) begin
      bud = j ^ 1;
      if (tree[tree_pos(lvl, bud)] != NODE_FREE) break;
      tree[tree_pos(lvl, j)]   = NODE_UNUSED;
      tree[tree_pos(lvl, bud)] = NODE_UNUSED;
      free_cnt[lvl] -= 2;
      lvl--;
      j = j / 2;
      tree[tree_pos(lvl, j)] = NODE_FREE;
      free_cnt[lvl]++;
    end
    r.sts = STS_OK;
    return r;
  endfunction

  always @(posedge clk) begin
    alloc_result_t want;
    if (rst) begin
      foreach (tree[i]) tree[i] = NODE_UNUSED;
      foreach (free_cnt[i]) free_cnt[i] = 0;
      tree[0] = NODE_FREE;
      free_cnt[0] = 1;
      base = BASE_RESET;
      result_q.delete();
      errors = 0;
    end else begin
      if (cfg_wen) base = cfg_wdata;
      if (s_tvalid && s_tready) begin
        if (cmd_t'(s_tdata[0]) == CMD_ALLOC) result_q.push_back(alloc_block(s_tdata[32:1]));
        else result_q.push_back(release_block(s_tdata[64:33]));
      end
      if (m_tvalid && m_tready) begin
        if (result_q.size() == 0) begin
          $error("result word with nothing expected: %h", m_tdata);
          errors++;
        end else begin
          want = result_q.pop_front();
          if (m_tdata[31:0] !== want.addr) begin
            $error("block_address expected %h actual %h", want.addr, m_tdata[31:0]);
            errors++;
          end
          if (m_tdata[33:32] !== want.sts) begin
            $error("status expected %0d actual %0d", want.sts, m_tdata[33:32]);
            errors++;
          end
        end
      end
    end
  end

endmodule

### sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// drives allocate and free commands into the buddy allocator under several
// base addresses and idle patterns; the checker predicts and compares
// ----------------------------------------------------------------------------
module tb;
  import bba_pkg::*;

  localparam int WATCHDOG = 5000;
  localparam int PHASE_WORDS = 245;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_wen = 1'b0;
  logic [31:0] cfg_wdata = '0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [71:0] s_tdata = '0;   // cmd, request_size, free_address, zero pad
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;        // block_address, status, zero pad

  int errors, pending;
  int sgap = 15, rgap = 48;
  int n_words = 0, n_alloc = 0, n_free = 0, n_base = 0;
  int idle_cycles = 0;
  cmd_t        issued_q [$];
  logic [31:0] live_q [$];
  logic [31:0] cur_base = BASE_RESET;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  buddy_block_allocator_unit i_dut (
    .clk, .rst, .cfg_wen, .cfg_wdata,
    .s_tvalid, .s_tready, .s_tdata,
    .m_tvalid, .m_tready, .m_tdata
  );

  bba_scoreboard i_chk (
    .clk, .rst, .cfg_wen, .cfg_wdata,
    .s_tvalid, .s_tready, .s_tdata,
    .m_tvalid, .m_tready, .m_tdata,
    .errors, .pending
  );

  // keep the addresses of live blocks so most frees are well formed
  always @(posedge clk) begin
    cmd_t c;
    if (!rst) begin
      if (s_tvalid && s_tready) issued_q.push_back(cmd_t'(s_tdata[0]));
      if (m_tvalid && m_tready && issued_q.size() > 0) begin
        c = issued_q.pop_front();
        if (c == CMD_ALLOC && status_t'(m_tdata[33:32]) == STS_OK)
          live_q.push_back(m_tdata[31:0]);
      end
    end
  end

  // receiver, with one long hold-off to back the block up
  always @(negedge clk) begin
    int hold;
    bit held;
    if (!held && n_words >= 700) begin
      held = 1'b1;
      hold = 400;
    end
    if (hold > 0) begin
      hold--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom % 100) >= rgap;
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send(cmd_t c, logic [31:0] size, logic [31:0] addr);
    while (($urandom % 100) < sgap) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {7'd0, addr, size, c};
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
    n_words++;
    if (c == CMD_ALLOC) n_alloc++;
    else n_free++;
    if (n_words == 400) begin
      sgap = 48;
      rgap = 15;
    end else if (n_words == 800) begin
      sgap = 0;
      rgap = 0;
    end
  endtask

  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  // release what is still live, then move the region
  task automatic rebase(logic [31:0] b);
    logic [31:0] a;
    wait_idle();
    while (live_q.size() > 0) begin
      a = live_q.pop_front();
      send(CMD_FREE, $urandom, a);
    end
    wait_idle();
    cfg_wen   <= 1'b1;
    cfg_wdata <= b;
    @(negedge clk);
    cfg_wen <= 1'b0;
    cur_base = b;
    n_base++;
  endtask

  task automatic random_word();
    int r, k;
    logic [31:0] a, sz;
    if (($urandom % 100) < 55) begin
      r = $urandom % 100;
      if (r < 40) sz = $urandom_range(0, 16384);
      else if (r < 70) sz = (32'd1 << $urandom_range(12, 20)) + $urandom_range(0, 2) - 1;
      else if (r < 85) sz = $urandom_range(0, 1 << 20);
      else if (r < 93) sz = (32'd1 << 20) + $urandom_range(1, 1 << 20);
      else sz = $urandom;
      send(CMD_ALLOC, sz, $urandom);
    end else begin
      r = $urandom % 100;
      if (live_q.size() > 0 && r < 75) begin
        k = $urandom_range(0, live_q.size() - 1);
        a = live_q[k];
        live_q.delete(k);
      end else if (r < 90) begin
        a = cur_base + ($urandom_range(0, 255) << MIN_BLOCK_EXP);
      end else begin
        a = $urandom;
      end
      send(CMD_FREE, $urandom, a);
    end
  endtask

  initial begin
    repeat (5) @(negedge clk);
    rst <= 1'b0;

    // zero, one, exact and just-over sizes; whole region and oversize
    send(CMD_ALLOC, 32'd0, '0);
    send(CMD_ALLOC, 32'd1, '0);
    send(CMD_ALLOC, 32'd4096, '0);
    send(CMD_ALLOC, 32'd4097, '1);
    send(CMD_ALLOC, 32'd1 << 20, '0);
    send(CMD_ALLOC, (32'd1 << 20) + 1, '0);
    send(CMD_ALLOC, 32'hffff_ffff, '0);
    // free of a free block start, an unaligned and a far address
    send(CMD_FREE, '1, BASE_RESET + 32'h8_0000);
    send(CMD_FREE, '0, BASE_RESET + 32'h1);
    send(CMD_FREE, '0, 32'hffff_ffff);
    send(CMD_FREE, '0, BASE_RESET + 32'h1000);
    send(CMD_FREE, '0, BASE_RESET + 32'h1000);
    send(CMD_FREE, '0, BASE_RESET);
    send(CMD_FREE, '0, BASE_RESET + 32'h2000);
    send(CMD_FREE, '0, BASE_RESET + 32'h4000);
    send(CMD_ALLOC, 32'd1 << 20, '0);
    send(CMD_ALLOC, 32'd1, '0);
    send(CMD_FREE, '0, BASE_RESET);
    send(CMD_ALLOC, 32'd1 << 19, '0);
    send(CMD_ALLOC, 32'd1 << 19, '0);
    send(CMD_ALLOC, 32'd1 << 19, '0);
    live_q.delete();
    send(CMD_FREE, '0, BASE_RESET);
    send(CMD_FREE, '0, BASE_RESET + 32'h8_0000);

    repeat (PHASE_WORDS) random_word();
    rebase(32'h0000_0000);
    repeat (PHASE_WORDS) random_word();
    // region wraps past the top of the address space
    rebase(32'hfff8_0000);
    repeat (PHASE_WORDS) random_word();
    rebase(32'hffff_ffff);
    repeat (PHASE_WORDS) random_word();
    rebase($urandom);
    repeat (PHASE_WORDS) random_word();

    wait_idle();
    repeat (300) @(negedge clk);
    $display("covered %0d words (%0d allocates, %0d frees) over %0d region bases",
             n_words, n_alloc, n_free, n_base + 1);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
